/* rtl/fmpam_pkg.sv */
// Shared types, constants and coefficient table for the FM phase-accumulator modulator.
package fmpam_pkg;

  localparam int PHASE_BITS    = 32;
  localparam int SAMPLE_BITS   = 16;
  localparam int COS_BITS      = 10;
  localparam int REM_BITS      = COS_BITS - 2;
  localparam int Q_FRAC        = 30;
  localparam int CI_BITS       = 32;
  localparam int DG_BITS       = 31;
  localparam int AG_BITS       = 16;
  localparam int AG_FRAC       = 12;
  localparam int MUL_BITS      = 33;
  localparam int PROD_BITS     = 64;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CARRIER   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEVIATION = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_AMPLITUDE = 2'd2;

  localparam logic [AG_BITS-1:0] AG_RESET = AG_BITS'(1 << AG_FRAC);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [PHASE_BITS-1:0]         phase_t;
  typedef logic signed [MUL_BITS-1:0]    mul_op_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic [Q_FRAC:0]               q30_t;

  localparam q30_t Q30_ONE = q30_t'(1) << Q_FRAC;

  typedef enum logic [3:0] {
    S_IDLE,
    S_M_SCALE,
    S_A_SCALE,
    S_M_OFF,
    S_A_OFF,
    S_A_Z,
    S_M_SQ,
    S_A_SQ,
    S_M_POLY,
    S_A_POLY,
    S_M_FIN,
    S_A_FIN
  } state_t;

  // sin(pi/2 z) Taylor coefficients in Q30, E seeds the Horner chain
  localparam q30_t SIN_E = q30_t'(172271);

  function automatic q30_t sin_coef(input logic [1:0] step);
    q30_t c;
    unique case (step)
      2'd0:    c = q30_t'(5026995);
      2'd1:    c = q30_t'(85569306);
      2'd2:    c = q30_t'(693598667);
      2'd3:    c = q30_t'(1686629713);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/fmpam_ifs.sv */
// Stream interfaces for message samples and modulated samples.
interface fmpam_msg_if;
  import fmpam_pkg::*;
  logic    valid;
  logic    ready;
  sample_t message_sample;
  modport source (output valid, output message_sample, input ready);
  modport sink (input valid, input message_sample, output ready);
endinterface

interface fmpam_mod_if;
  import fmpam_pkg::*;
  logic    valid;
  logic    ready;
  sample_t modulated_sample;
  modport source (output valid, output modulated_sample, input ready);
  modport sink (input valid, input modulated_sample, output ready);
endinterface

/* rtl/fmpam_mul.sv */
// Shared signed multiplier with registered product.
module fmpam_mul (
  input  logic              clk,
  input  logic              mul_en,
  input  fmpam_pkg::mul_op_t op_a,
  input  fmpam_pkg::mul_op_t op_b,
  output fmpam_pkg::prod_t   prod_r
);
  import fmpam_pkg::*;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= PROD_BITS'(op_a * op_b);
    end
  end

endmodule

/* rtl/fm_phase_accumulator_modulator.sv */
// FM phase-accumulator modulator top level: sequencer around one shared multiplier.
// Items are processed one at a time on the single 33x33 multiplier, used
// eight times per item, each product followed by a fix-up step, plus a
// phase fold step and an idle state that takes the next input transaction.
// A waiting result does not stall the next input; the last step holds until the output slot frees.
// Reset (rst_n, synchronous, active low): phase 0, carrier 0, deviation 0, amplitude 1.0.
module fm_phase_accumulator_modulator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  fmpam_msg_if.sink                             in_ch,
  fmpam_mod_if.source                           out_ch,
  input  logic                                  cfg_we,
  input  logic [fmpam_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [fmpam_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import fmpam_pkg::*;

  state_t                 state_r, state_nxt;
  logic [CI_BITS-1:0]     ci_r;
  logic [DG_BITS-1:0]     dg_r;
  logic [AG_BITS-1:0]     ag_r;
  phase_t                 phase_r, phase_nxt;
  mul_op_t                a_r, a_nxt;
  mul_op_t                b_r, b_nxt;
  logic [1:0]             quad_r, quad_nxt;
  q30_t                   z_r, z_nxt;
  q30_t                   z2_r, z2_nxt;
  logic [1:0]             cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  sample_t                out_sample_r, out_sample_nxt;
  prod_t                  prod_r;
  logic                   mul_en;
  logic                   in_take;
  logic                   slot_free;

  logic signed [MUL_BITS:0]   scale_sum;
  logic signed [21:0]         scale_q;
  sample_t                    scaled;
  logic signed [47:0]         off_sum;
  phase_t                     off_val;
  q30_t                       z_raw;
  q30_t                       z_fold;
  q30_t                       prod_q;
  q30_t                       poly_s;
  logic [Q_FRAC+1:0]          mag_sum;
  logic [16:0]                mag;
  sample_t                    mag_clip;

  fmpam_mul u_mul (
    .clk    (clk),
    .mul_en (mul_en),
    .op_a   (a_r),
    .op_b   (b_r),
    .prod_r (prod_r)
  );

  assign in_ch.ready             = (state_r == S_IDLE);
  assign in_take                 = in_ch.valid && in_ch.ready;
  assign slot_free               = !out_valid_r || out_ch.ready;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.modulated_sample = out_sample_r;
  assign mul_en = (state_r == S_M_SCALE) || (state_r == S_M_OFF) || (state_r == S_M_SQ) ||
                  (state_r == S_M_POLY) || (state_r == S_M_FIN);

  // fix-up arithmetic on the registered product
  always_comb begin
    scale_sum = prod_r[MUL_BITS:0] + (MUL_BITS+1)'(2048);
    scale_q   = scale_sum[MUL_BITS:AG_FRAC];
    if (scale_q > 22'sd32767) begin
      scaled = 16'sh7fff;
    end else if (scale_q < -22'sd32768) begin
      scaled = 16'sh8000;
    end else begin
      scaled = scale_q[SAMPLE_BITS-1:0];
    end
    off_sum  = prod_r[47:0] + 48'sd16384;
    off_val  = off_sum[46:15];
    z_raw    = q30_t'(phase_r[PHASE_BITS-3 -: REM_BITS]) << (Q_FRAC - REM_BITS);
    z_fold   = phase_r[PHASE_BITS-2] ? z_raw : (Q30_ONE - z_raw);
    prod_q   = prod_r[Q_FRAC +: Q_FRAC+1];
    poly_s   = sin_coef(cnt_r) - prod_q;
    mag_sum  = {1'b0, prod_q} + (Q_FRAC+2)'(16384);
    mag      = mag_sum[Q_FRAC+1:15];
    mag_clip = mag[16:15] != 2'b00 ? 16'sh7fff : sample_t'(mag[14:0]);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_take) state_nxt = S_M_SCALE;
      S_M_SCALE: state_nxt = S_A_SCALE;
      S_A_SCALE: state_nxt = S_M_OFF;
      S_M_OFF:   state_nxt = S_A_OFF;
      S_A_OFF:   state_nxt = S_A_Z;
      S_A_Z:     state_nxt = S_M_SQ;
      S_M_SQ:    state_nxt = S_A_SQ;
      S_A_SQ:    state_nxt = S_M_POLY;
      S_M_POLY:  state_nxt = S_A_POLY;
      S_A_POLY:  state_nxt = (cnt_r == 2'd3) ? S_M_FIN : S_M_POLY;
      S_M_FIN:   state_nxt = S_A_FIN;
      S_A_FIN:   if (slot_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    a_nxt          = a_r;
    b_nxt          = b_r;
    phase_nxt      = phase_r;
    quad_nxt       = quad_r;
    z_nxt          = z_r;
    z2_nxt         = z2_r;
    cnt_nxt        = cnt_r;
    out_sample_nxt = out_sample_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    unique case (state_r)
      S_IDLE: begin
        a_nxt = MUL_BITS'(in_ch.message_sample);
        b_nxt = signed'(MUL_BITS'(ag_r));
      end
      S_A_SCALE: begin
        a_nxt = MUL_BITS'(scaled);
        b_nxt = signed'(MUL_BITS'(dg_r));
      end
      S_A_OFF: begin
        phase_nxt = phase_r + ci_r + off_val;
      end
      S_A_Z: begin
        quad_nxt = phase_r[PHASE_BITS-1 -: 2];
        z_nxt    = z_fold;
        a_nxt    = signed'(MUL_BITS'(z_fold));
        b_nxt    = signed'(MUL_BITS'(z_fold));
      end
      S_A_SQ: begin
        z2_nxt  = prod_q;
        a_nxt   = signed'(MUL_BITS'(SIN_E));
        b_nxt   = signed'(MUL_BITS'(prod_q));
        cnt_nxt = 2'd0;
      end
      S_A_POLY: begin
        a_nxt   = signed'(MUL_BITS'(poly_s));
        b_nxt   = signed'(MUL_BITS'((cnt_r == 2'd3) ? z_r : z2_r));
        cnt_nxt = cnt_r + 2'd1;
      end
      S_A_FIN: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = (quad_r[1] ^ quad_r[0]) ? -mag_clip : mag_clip;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    quad_r       <= quad_nxt;
    z_r          <= z_nxt;
    z2_r         <= z2_nxt;
    out_sample_r <= out_sample_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ci_r <= '0;
      dg_r <= '0;
      ag_r <= AG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CARRIER:   ci_r <= cfg_data[CI_BITS-1:0];
        CFG_DEVIATION: dg_r <= cfg_data[DG_BITS-1:0];
        CFG_AMPLITUDE: ag_r <= cfg_data[AG_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> !in_ch.ready)
    else $error("input taken while an item is in flight");

  a_result_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_A_FIN))
    else $error("result raised outside the final step");

  a_poly_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_POLY && cnt_r == 2'd3) |=> state_r == S_M_FIN)
    else $error("polynomial loop did not end after four steps");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_A_OFF) |=> $stable(phase_r))
    else $error("phase changed outside the update step");

endmodule
